@@ sv/ilie_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list package
// Word types, operation codes and status codes shared by the list block.
// ----------------------------------------------------------------------------
package ilie_pkg;

    // Fixed field widths of the request and result words
    localparam int OP_BITS       = 3;
    localparam int POS_BITS      = 7;
    localparam int PORT_WORD_W   = 32;
    localparam int ST_BITS       = 2;

    // Operation codes carried in the opcode field
    typedef enum logic [OP_BITS-1:0] {
        OP_APPEND = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_READ   = 3'd4,
        OP_WRITE  = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    // Result status codes
    typedef enum logic [ST_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Per-cycle command broadcast along the row of cells
    typedef enum logic [1:0] {
        CK_HOLD = 2'd0,
        CK_PUT  = 2'd1,
        CK_INS  = 2'd2,
        CK_ERA  = 2'd3
    } t_cell_op;

    // Request word
    typedef struct packed {
        logic [OP_BITS-1:0]            opcode;
        logic [POS_BITS-1:0]           position;
        logic signed [PORT_WORD_W-1:0] word_in;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic signed [PORT_WORD_W-1:0] word_out;
        logic [POS_BITS-1:0]           where;
        logic [POS_BITS-1:0]           count;
        logic [ST_BITS-1:0]            status;
    } t_out_word;

endpackage

@@ sv/indexed_list_insert_erase_unit.sv @@
// ----------------------------------------------------------------------------
// Indexed list with insert and erase
// Ordered list of words kept in a row of cells with a live count. Insert and
// erase move every later entry one cell at once.
// ----------------------------------------------------------------------------
//  Channel   Valid        Stall        Word
//  request   i_in_valid   o_in_stall   i_in_word  (opcode, position, word_in)
//  result    o_out_valid  i_out_stall  o_out_word (word_out, where, count, status)
//
//  Every operation except read writes its result word when accepted; a read first
//  loads the registered OR tree for the addressed cell, and S_READ writes it out.
//  One result word is produced per request word.
//  Reset clears the count and the handshake state; cell contents are kept.
//  A waiting result does not block the next request unless it is stalled.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase_unit #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ilie_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ilie_pkg::t_out_word o_out_word
);
    import ilie_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int XW    = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    t_out_word            r_out;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out_word            r_pend;
    logic                 r_rd_ok;

    t_op                  w_op;
    logic [XW-1:0]        w_pos;
    logic [XW-1:0]        w_cnt;
    logic [XW-1:0]        w_clamp;
    logic [XW-1:0]        w_where;
    logic                 w_full;
    logic                 w_in_range;
    logic                 w_rd_ok;
    t_status              w_status;
    t_cell_op             w_kind;
    t_cell_op             w_cell_op;
    logic [XW-1:0]        w_cell_pos;
    logic [WORD_BITS-1:0] w_word;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_is_read;
    logic [WORD_BITS-1:0] w_tree;
    t_out_word            w_res;
    t_out_word            w_rd_res;

    logic [WORD_BITS-1:0] w_entry [DEPTH];
    logic [WORD_BITS-1:0] w_rd    [DEPTH];

    // Handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Request decode
    assign w_op       = t_op'(i_in_word.opcode);
    assign w_pos      = XW'(i_in_word.position);
    assign w_cnt      = XW'(r_count);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_in_range = (w_pos < w_cnt);
    assign w_clamp    = (w_pos > w_cnt) ? w_cnt : w_pos;
    assign w_word     = WORD_BITS'($unsigned(i_in_word.word_in));
    assign w_is_read  = (w_op == OP_READ);

    // Operation outcome: status, slot, new count and the cell command.
    always_comb begin
        w_status   = ST_OK;
        w_where    = '0;
        n_count    = r_count;
        w_kind     = CK_HOLD;
        w_cell_pos = w_pos;
        w_rd_ok    = 1'b0;
        case (w_op)
            OP_APPEND: begin
                w_where = w_cnt;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_kind     = CK_PUT;
                    w_cell_pos = w_cnt;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    w_where = w_cnt - XW'(1);
                end
            end
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                    w_where  = w_cnt;
                end else begin
                    w_kind     = CK_INS;
                    w_cell_pos = w_clamp;
                    w_where    = w_clamp;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            OP_ERASE: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                    w_where  = w_cnt;
                end else begin
                    w_kind  = CK_ERA;
                    w_where = w_pos;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                    w_where  = w_cnt;
                end else begin
                    w_where = w_pos;
                    w_rd_ok = 1'b1;
                end
            end
            OP_WRITE: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                    w_where  = w_cnt;
                end else begin
                    w_kind  = CK_PUT;
                    w_where = w_pos;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    assign w_cell_op = w_in_acc ? w_kind : CK_HOLD;

    // Result word for everything except a pending read value
    always_comb begin
        w_res.word_out = '0;
        w_res.where    = POS_BITS'(w_where);
        w_res.count    = POS_BITS'(n_count);
        w_res.status   = w_status;
    end

    // Read result: the held fields with the collected value when in range
    always_comb begin
        w_rd_res          = r_pend;
        w_rd_res.word_out = r_rd_ok ? PORT_WORD_W'(w_tree) : '0;
    end

    // Row of storage cells, each linked to its neighbors; the ends see zero.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WORD_BITS-1:0] w_left;
        logic [WORD_BITS-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[k+1];
        end
        ilie_cell #(
            .WORD_BITS (WORD_BITS),
            .XW        (XW),
            .IDX       (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_pos   (w_cell_pos),
            .i_cnt   (w_cnt),
            .i_word  (w_word),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[k]),
            .o_rd    (w_rd[k])
        );
    end

    // Read collection
    ilie_read_tree #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_read_tree (
        .i_clk  (i_clk),
        .i_load (w_in_acc && w_is_read),
        .i_rd   (w_rd),
        .o_data (w_tree)
    );

    // Result valid: held while stalled, set when a result word is produced.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (r_state == S_IDLE && w_in_acc && !w_is_read) n_out_valid = 1'b1;
        if (r_state == S_READ && w_out_free) n_out_valid = 1'b1;
    end

    // Count, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_count <= n_count;
                        if (w_is_read) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            if (w_is_read) begin
                r_pend  <= w_res;
                r_rd_ok <= w_rd_ok;
            end else begin
                r_out <= w_res;
            end
        end else if (r_state == S_READ && w_out_free) begin
            r_out <= w_rd_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("live count exceeds the store depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> o_in_stall)
        else $error("request taken while a read is being collected");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the list");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_read) |=> (r_state == S_READ && !r_out_valid ||
                                     r_state == S_READ && $past(r_out_valid)))
        else $error("read did not enter the collection cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_status != ST_OK) |=> (r_count == $past(r_count)))
        else $error("refused operation changed the count");

endmodule

@@ sv/ilie_cell.sv @@
// ----------------------------------------------------------------------------
// Indexed list storage cell
// Holds one list entry. It takes the broadcast value on a direct store and at
// the insert point, else its left neighbor on insert, right neighbor on erase.
// ----------------------------------------------------------------------------
module ilie_cell #(
    parameter int WORD_BITS = 32,
    parameter int XW        = 7,
    parameter int IDX       = 0
) (
    input  logic                    i_clk,
    input  ilie_pkg::t_cell_op      i_op,
    input  logic [XW-1:0]           i_pos,
    input  logic [XW-1:0]           i_cnt,
    input  logic [WORD_BITS-1:0]    i_word,
    input  logic [WORD_BITS-1:0]    i_left,
    input  logic [WORD_BITS-1:0]    i_right,
    output logic [WORD_BITS-1:0]    o_entry,
    output logic [WORD_BITS-1:0]    o_rd
);
    import ilie_pkg::*;

    localparam logic [XW-1:0] MY_IDX   = XW'(IDX);
    localparam logic [XW-1:0] NEXT_IDX = XW'(IDX + 1);

    logic [WORD_BITS-1:0] r_entry;
    logic [WORD_BITS-1:0] n_entry;
    logic                 w_hit;

    assign w_hit = (i_pos == MY_IDX);

    // Pick the new entry from the command and this cell's place in the list.
    always_comb begin
        n_entry = r_entry;
        case (i_op)
            CK_PUT: begin
                if (w_hit) n_entry = i_word;
            end
            CK_INS: begin
                if (w_hit) begin
                    n_entry = i_word;
                end else if ((MY_IDX > i_pos) && (MY_IDX <= i_cnt)) begin
                    n_entry = i_left;
                end
            end
            CK_ERA: begin
                if ((MY_IDX >= i_pos) && (NEXT_IDX < i_cnt)) n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Entry storage has no reset; only written entries are ever read.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_rd    = w_hit ? r_entry : '0;

endmodule

@@ sv/ilie_read_tree.sv @@
// ----------------------------------------------------------------------------
// Indexed list read collector
// Gathers the one selected cell's entry through a registered OR tree:
// groups of eight are combined and registered, then the groups are combined.
// ----------------------------------------------------------------------------
module ilie_read_tree #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [WORD_BITS-1:0] i_rd [DEPTH],
    output logic [WORD_BITS-1:0] o_data
);
    localparam int GRP  = 8;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    logic [WORD_BITS-1:0] r_grp [NGRP];
    logic [WORD_BITS-1:0] n_grp [NGRP];

    // First level: combine each group of cells.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < DEPTH) n_grp[g] = n_grp[g] | i_rd[g * GRP + j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int g = 0; g < NGRP; g++) r_grp[g] <= n_grp[g];
        end
    end

    // Second level: combine the registered groups.
    always_comb begin
        o_data = '0;
        for (int g = 0; g < NGRP; g++) o_data = o_data | r_grp[g];
    end

endmodule
